// ----- hdl/multi_window_blended_average_unit_defines.svh -----
// Assertion macros for the multi-window blended average unit.
`ifndef MULTI_WINDOW_BLENDED_AVERAGE_UNIT_DEFINES_SVH
`define MULTI_WINDOW_BLENDED_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MWBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MWBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mwba_pkg.sv -----
// Shared sizes, derived widths and divider status type for the blended average unit.
`default_nettype none

package mwba_pkg;

    // window sizes and sample width
    localparam int SHORT_SLOTS = 12;
    localparam int MID_SLOTS   = 10;
    localparam int LONG_SLOTS  = 6;
    localparam int SAMPLE_BITS = 32;

    // blend period of the long level (mid period is SHORT_SLOTS)
    localparam int LONG_PERIOD = SHORT_SLOTS * MID_SLOTS;

    // one slot memory holds all three levels back to back
    localparam int TOTAL_SLOTS = SHORT_SLOTS + MID_SLOTS + LONG_SLOTS;
    localparam int MID_BASE    = SHORT_SLOTS;
    localparam int LONG_BASE   = SHORT_SLOTS + MID_SLOTS;
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);

    localparam int MAX_SLOTS_SM = (SHORT_SLOTS > MID_SLOTS) ? SHORT_SLOTS : MID_SLOTS;
    localparam int MAX_SLOTS    = (MAX_SLOTS_SM > LONG_SLOTS) ? MAX_SLOTS_SM : LONG_SLOTS;
    localparam int KW           = $clog2(MAX_SLOTS + 1);

    // divisor covers slot counts and the long period; dividend adds the sample bits
    localparam int DVS_A = $clog2(MAX_SLOTS + 1);
    localparam int DVS_B = $clog2(LONG_PERIOD + 1);
    localparam int DVS_W = (DVS_A > DVS_B) ? DVS_A : DVS_B;
    localparam int DVD_W = SAMPLE_BITS + DVS_W;

    // per-level counters
    localparam int SI_W  = $clog2(SHORT_SLOTS);
    localparam int MI_W  = $clog2(MID_SLOTS);
    localparam int LI_W  = $clog2(LONG_SLOTS);
    localparam int LPH_W = $clog2(LONG_PERIOD);

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/mwba_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module mwba_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered: rdata follows raddr in the next cycle
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/mwba_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module mwba_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mwba_pkg::DVD_W-1:0]  dividend,
    input  wire logic [mwba_pkg::DVS_W-1:0]  divisor,
    output logic      [mwba_pkg::DVD_W-1:0]  quotient,
    output mwba_pkg::div_stat_t              stat
);

    localparam int CW = $clog2(mwba_pkg::DVD_W + 1);

    logic [mwba_pkg::DVD_W-1:0] dvd_reg;
    logic [mwba_pkg::DVS_W-1:0] dvs_reg;
    logic [mwba_pkg::DVS_W-1:0] rem_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [mwba_pkg::DVS_W:0]   rem_sh;
    logic [mwba_pkg::DVS_W:0]   rem_sub;
    logic                       q_bit;
    logic [mwba_pkg::DVS_W-1:0] rem_next;

    // one trial subtraction
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[mwba_pkg::DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_next = q_bit ? rem_sub[mwba_pkg::DVS_W-1:0] : rem_sh[mwba_pkg::DVS_W-1:0];
    end

    // quotient shifts in where the dividend shifts out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= CW'(mwba_pkg::DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[mwba_pkg::DVD_W-2:0], q_bit};
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/multi_window_blended_average_unit.sv -----
// Top level: slot memory sequencer for the short, mid and long blended averages.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, sample       | to block
//   out     | out_valid, out_stall, avg_short, | from block
//           | avg_mid, avg_long                |
//
// One word at a time. The time a word takes is set by the bit-serial divider run for the
// three means and the two blends, plus one memory read per slot for each mean.
// Reset clears all valid marks, bases and counters; slot memory needs no clearing.
// in_stall is high from acceptance until the result is loaded into the output
// register; a held result waits there under out_stall while the next word is taken.
`default_nettype none
`include "multi_window_blended_average_unit_defines.svh"

module multi_window_blended_average_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mwba_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [mwba_pkg::SAMPLE_BITS-1:0] avg_short,
    output logic      [mwba_pkg::SAMPLE_BITS-1:0] avg_mid,
    output logic      [mwba_pkg::SAMPLE_BITS-1:0] avg_long
);

    localparam int SB    = mwba_pkg::SAMPLE_BITS;
    localparam int AW    = mwba_pkg::ADDR_W;
    localparam int KW    = mwba_pkg::KW;
    localparam int DVS_W = mwba_pkg::DVS_W;
    localparam int DVD_W = mwba_pkg::DVD_W;
    localparam int SI_W  = mwba_pkg::SI_W;
    localparam int MI_W  = mwba_pkg::MI_W;
    localparam int LI_W  = mwba_pkg::LI_W;
    localparam int LPH_W = mwba_pkg::LPH_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_MDIV,
        ST_MWAIT,
        ST_BRD,
        ST_BLAT,
        ST_BSEL,
        ST_MUL1,
        ST_MUL2,
        ST_BDIV,
        ST_BWAIT,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        LVL_SHORT,
        LVL_MID,
        LVL_LONG
    } level_t;

    state_t                          state_reg;
    level_t                          lvl_reg;

    // position counters standing for the poll index
    logic [SI_W-1:0]                 si_reg;
    logic [MI_W-1:0]                 mi_reg;
    logic [LPH_W-1:0]                lph_reg;
    logic [LI_W-1:0]                 li_reg;

    logic [mwba_pkg::TOTAL_SLOTS-1:0] valid_reg;

    logic [SB-1:0]                   mid_base_reg;
    logic                            mid_base_vld_reg;
    logic [SB-1:0]                   long_base_reg;
    logic                            long_base_vld_reg;

    // walk state
    logic [KW-1:0]                   k_reg;
    logic                            pend_reg;
    logic                            vpipe_reg;
    logic [DVD_W-1:0]                sum_reg;
    logic [DVS_W-1:0]                cnt_reg;

    logic [SB-1:0]                   s_avg_reg;
    logic [SB-1:0]                   m_avg_reg;
    logic [SB-1:0]                   l_avg_reg;
    logic [SB-1:0]                   wval_reg;
    logic [DVD_W-1:0]                prod_reg;
    logic [DVD_W-1:0]                num_reg;

    logic                            out_valid_reg;
    logic [SB-1:0]                   avg_short_reg;
    logic [SB-1:0]                   avg_mid_reg;
    logic [SB-1:0]                   avg_long_reg;

    // per-level selection
    logic [AW-1:0]                   lvl_base;
    logic [KW-1:0]                   lvl_n;
    logic [AW-1:0]                   lvl_idx;
    logic [SB-1:0]                   lvl_cur;
    logic [SB-1:0]                   lvl_bval;
    logic                            lvl_bvld;
    logic [DVS_W-1:0]                lvl_phase;
    logic [DVS_W-1:0]                lvl_period;
    logic [AW-1:0]                   slot_addr;
    logic [AW-1:0]                   walk_addr;
    logic [DVS_W-1:0]                wnew;
    logic [DVS_W-1:0]                wold;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [SB-1:0]                   ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [SB-1:0]                   ram_rdata;

    logic [SB-1:0]                   mul_a;
    logic [DVS_W-1:0]                mul_b;
    logic [DVD_W-1:0]                mul_out;

    logic                            div_start;
    logic [DVD_W-1:0]                div_dividend;
    logic [DVS_W-1:0]                div_divisor;
    logic [DVD_W-1:0]                div_quo;
    mwba_pkg::div_stat_t             div_stat;

    logic                            in_acc;
    logic                            out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign avg_short = avg_short_reg;
    assign avg_mid   = avg_mid_reg;
    assign avg_long  = avg_long_reg;

    // level decode
    always_comb
    begin
        case (lvl_reg)
            LVL_MID:
            begin
                lvl_base   = AW'(mwba_pkg::MID_BASE);
                lvl_n      = KW'(mwba_pkg::MID_SLOTS);
                lvl_idx    = AW'(mi_reg);
                lvl_cur    = s_avg_reg;
                lvl_bval   = mid_base_reg;
                lvl_bvld   = mid_base_vld_reg;
                lvl_phase  = DVS_W'(si_reg);
                lvl_period = DVS_W'(mwba_pkg::SHORT_SLOTS);
            end
            LVL_LONG:
            begin
                lvl_base   = AW'(mwba_pkg::LONG_BASE);
                lvl_n      = KW'(mwba_pkg::LONG_SLOTS);
                lvl_idx    = AW'(li_reg);
                lvl_cur    = m_avg_reg;
                lvl_bval   = long_base_reg;
                lvl_bvld   = long_base_vld_reg;
                lvl_phase  = DVS_W'(lph_reg);
                lvl_period = DVS_W'(mwba_pkg::LONG_PERIOD);
            end
            default:
            begin
                lvl_base   = '0;
                lvl_n      = KW'(mwba_pkg::SHORT_SLOTS);
                lvl_idx    = AW'(si_reg);
                lvl_cur    = s_avg_reg;
                lvl_bval   = mid_base_reg;
                lvl_bvld   = 1'b0;
                lvl_phase  = DVS_W'(si_reg);
                lvl_period = DVS_W'(mwba_pkg::SHORT_SLOTS);
            end
        endcase
        slot_addr = lvl_base + lvl_idx;
        walk_addr = lvl_base + AW'(k_reg);
        wnew      = lvl_phase + DVS_W'(1);
        wold      = lvl_period - wnew;
    end

    // memory ports
    always_comb
    begin
        ram_we    = in_acc || (state_reg == ST_WRITE);
        ram_waddr = in_acc ? AW'(si_reg) : slot_addr;
        ram_wdata = in_acc ? sample : wval_reg;
        ram_raddr = (state_reg == ST_WALK) ? walk_addr : slot_addr;
    end

    // shared multiplier: new weight first, base weight second
    always_comb
    begin
        mul_a   = (state_reg == ST_MUL1) ? lvl_cur : lvl_bval;
        mul_b   = (state_reg == ST_MUL1) ? wnew : wold;
        mul_out = {{DVS_W{1'b0}}, mul_a} * {{SB{1'b0}}, mul_b};
    end

    // divider operands: mean or blend
    always_comb
    begin
        div_start    = (state_reg == ST_MDIV) || (state_reg == ST_BDIV);
        div_dividend = (state_reg == ST_MDIV) ? sum_reg : num_reg;
        div_divisor  = (state_reg == ST_MDIV) ? cnt_reg : lvl_period;
    end

    mwba_ram #(
        .DEPTH (mwba_pkg::TOTAL_SLOTS),
        .WIDTH (SB)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mwba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            lvl_reg           <= LVL_SHORT;
            si_reg            <= '0;
            mi_reg            <= '0;
            lph_reg           <= '0;
            li_reg            <= '0;
            valid_reg         <= '0;
            mid_base_reg      <= '0;
            mid_base_vld_reg  <= 1'b0;
            long_base_reg     <= '0;
            long_base_vld_reg <= 1'b0;
            k_reg             <= '0;
            pend_reg          <= 1'b0;
            vpipe_reg         <= 1'b0;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        valid_reg[AW'(si_reg)] <= 1'b1;
                        lvl_reg   <= LVL_SHORT;
                        k_reg     <= '0;
                        pend_reg  <= 1'b0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_WALK;
                    end
                end

                // read each slot of the level, add the valid ones
                ST_WALK:
                begin
                    if (pend_reg && vpipe_reg)
                    begin
                        sum_reg <= sum_reg + DVD_W'(ram_rdata);
                        cnt_reg <= cnt_reg + DVS_W'(1);
                    end
                    if (k_reg != lvl_n)
                    begin
                        pend_reg  <= 1'b1;
                        vpipe_reg <= valid_reg[walk_addr];
                        k_reg     <= k_reg + KW'(1);
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_MDIV;
                    end
                end

                ST_MDIV:
                begin
                    state_reg <= ST_MWAIT;
                end

                // mean done: move up one level or finish
                ST_MWAIT:
                begin
                    if (div_stat.done)
                    begin
                        case (lvl_reg)
                            LVL_SHORT:
                            begin
                                s_avg_reg <= div_quo[SB-1:0];
                                lvl_reg   <= LVL_MID;
                                state_reg <= (si_reg == '0) ? ST_BRD : ST_BSEL;
                            end
                            LVL_MID:
                            begin
                                m_avg_reg <= div_quo[SB-1:0];
                                lvl_reg   <= LVL_LONG;
                                state_reg <= (lph_reg == '0) ? ST_BRD : ST_BSEL;
                            end
                            default:
                            begin
                                l_avg_reg <= div_quo[SB-1:0];
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end

                // period start: old slot becomes the blend base
                ST_BRD:
                begin
                    state_reg <= ST_BLAT;
                end

                ST_BLAT:
                begin
                    if (lvl_reg == LVL_LONG)
                    begin
                        long_base_reg     <= ram_rdata;
                        long_base_vld_reg <= valid_reg[slot_addr];
                    end
                    else
                    begin
                        mid_base_reg     <= ram_rdata;
                        mid_base_vld_reg <= valid_reg[slot_addr];
                    end
                    state_reg <= ST_BSEL;
                end

                ST_BSEL:
                begin
                    if (lvl_bvld)
                    begin
                        state_reg <= ST_MUL1;
                    end
                    else
                    begin
                        wval_reg  <= lvl_cur;
                        state_reg <= ST_WRITE;
                    end
                end

                ST_MUL1:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= ST_MUL2;
                end

                ST_MUL2:
                begin
                    num_reg   <= prod_reg + mul_out;
                    state_reg <= ST_BDIV;
                end

                ST_BDIV:
                begin
                    state_reg <= ST_BWAIT;
                end

                ST_BWAIT:
                begin
                    if (div_stat.done)
                    begin
                        wval_reg  <= div_quo[SB-1:0];
                        state_reg <= ST_WRITE;
                    end
                end

                // store the slot (blended, or the plain mean without a valid base), then average the level
                ST_WRITE:
                begin
                    valid_reg[slot_addr] <= 1'b1;
                    k_reg     <= '0;
                    pend_reg  <= 1'b0;
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_WALK;
                end

                // load result once the output register is free, advance position
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        avg_short_reg <= s_avg_reg;
                        avg_mid_reg   <= m_avg_reg;
                        avg_long_reg  <= l_avg_reg;
                        out_valid_reg <= 1'b1;
                        if (si_reg == SI_W'(mwba_pkg::SHORT_SLOTS - 1))
                        begin
                            si_reg <= '0;
                            if (mi_reg == MI_W'(mwba_pkg::MID_SLOTS - 1))
                            begin
                                mi_reg <= '0;
                            end
                            else
                            begin
                                mi_reg <= mi_reg + MI_W'(1);
                            end
                        end
                        else
                        begin
                            si_reg <= si_reg + SI_W'(1);
                        end
                        if (lph_reg == LPH_W'(mwba_pkg::LONG_PERIOD - 1))
                        begin
                            lph_reg <= '0;
                            if (li_reg == LI_W'(mwba_pkg::LONG_SLOTS - 1))
                            begin
                                li_reg <= '0;
                            end
                            else
                            begin
                                li_reg <= li_reg + LI_W'(1);
                            end
                        end
                        else
                        begin
                            lph_reg <= lph_reg + LPH_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks
    `MWBA_ASSERT_IMP(a_div_busy_wait, div_stat.busy, state_reg == ST_MWAIT || state_reg == ST_BWAIT, "divider running outside a wait state")
    `MWBA_ASSERT_IMP(a_walk_bound, state_reg == ST_WALK, k_reg <= lvl_n, "slot walk ran past the level")
    `MWBA_ASSERT_IMP(a_mean_nonempty, state_reg == ST_MDIV, cnt_reg != '0, "mean started over no valid slot")
    `MWBA_ASSERT_NXT(a_out_load, state_reg == ST_OUT && out_free, out_valid_reg, "result not loaded")

endmodule

`default_nettype wire

// ----- dv/multi_window_blended_average_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the blended average unit: directed sample table, then random samples.
module multi_window_blended_average_unit_tb;
    import mwba_pkg::*;

    localparam int WRAP_LEN     = SHORT_SLOTS * MID_SLOTS * LONG_SLOTS;
    localparam int RANDOM_WORDS = 1500;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_WIN      = 64;

    // window levels inside the predictor's slot store
    localparam int LVL_SHORT = 0;
    localparam int LVL_MID   = 1;
    localparam int LVL_LONG  = 2;

    typedef logic [SAMPLE_BITS-1:0] word_t;

    typedef struct packed {
        word_t s;
        word_t m;
        word_t l;
    } avg_set_t;

    typedef struct packed {
        word_t    smp;
        logic     known;
        avg_set_t avg;
    } sample_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t sample = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t avg_short;
    word_t avg_mid;
    word_t avg_long;

    multi_window_blended_average_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .avg_short (avg_short),
        .avg_mid   (avg_mid),
        .avg_long  (avg_long)
    );

    always #2 clk = ~clk;

    // predictor state: slot values and valid marks per level, blend anchors, poll counter
    bit [SAMPLE_BITS-1:0] win_val[3][MAX_WIN];
    bit                   win_ok[3][MAX_WIN];
    word_t                mid_anchor = '0;
    bit                   mid_anchor_ok = 1'b0;
    word_t                long_anchor = '0;
    bit                   long_anchor_ok = 1'b0;
    int unsigned          poll_cnt = 0;

    avg_set_t    avg_exp_q[$];
    sample_row_t dir_rows[$];
    int          errors = 0;
    int          idle_cycles = 0;
    word_t       drift_level = 32'h0010_0000;

    // truncated mean over the valid slots of one level
    function automatic word_t mean_of(input int lvl, input int n);
        logic [63:0] sum;
        int          cnt;
        sum = '0;
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            if (win_ok[lvl][i])
            begin
                sum += 64'(win_val[lvl][i]);
                cnt++;
            end
        end
        return (cnt != 0) ? word_t'(sum / 64'(cnt)) : '0;
    endfunction

    // new value weighted (phase+1)/period against the anchor, exact in 64 bits
    function automatic word_t blended(input word_t cur, input word_t anchor, input bit anchor_ok,
                                      input int phase, input int period);
        logic [63:0] w;
        if (!anchor_ok)
            return cur;
        w = 64'(phase + 1);
        return word_t'((64'(cur) * w + 64'(anchor) * (64'(period) - w)) / 64'(period));
    endfunction

    // advance the predictor by one sample and return the three averages
    function automatic avg_set_t predict_averages(input word_t smp);
        int       pc;
        int       mph;
        int       mi;
        int       lph;
        int       li;
        avg_set_t r;
        pc  = poll_cnt % WRAP_LEN;
        mph = pc % SHORT_SLOTS;
        mi  = (pc / SHORT_SLOTS) % MID_SLOTS;
        lph = pc % LONG_PERIOD;
        li  = (pc / LONG_PERIOD) % LONG_SLOTS;

        win_val[LVL_SHORT][mph] = smp;
        win_ok[LVL_SHORT][mph]  = 1'b1;
        r.s = mean_of(LVL_SHORT, SHORT_SLOTS);

        if (mph == 0)
        begin
            mid_anchor    = win_val[LVL_MID][mi];
            mid_anchor_ok = win_ok[LVL_MID][mi];
        end
        win_val[LVL_MID][mi] = blended(r.s, mid_anchor, mid_anchor_ok, mph, SHORT_SLOTS);
        win_ok[LVL_MID][mi]  = 1'b1;
        r.m = mean_of(LVL_MID, MID_SLOTS);

        if (lph == 0)
        begin
            long_anchor    = win_val[LVL_LONG][li];
            long_anchor_ok = win_ok[LVL_LONG][li];
        end
        win_val[LVL_LONG][li] = blended(r.m, long_anchor, long_anchor_ok, lph, LONG_PERIOD);
        win_ok[LVL_LONG][li]  = 1'b1;
        r.l = mean_of(LVL_LONG, LONG_SLOTS);

        poll_cnt = (pc + 1) % WRAP_LEN;
        return r;
    endfunction

    // sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 24);
        else
            return $urandom_range(60, 300);
    endfunction

    // random sample: full range, extremes, or a slowly drifting measurement
    function automatic word_t next_sample();
        int r;
        int delta;
        r = $urandom_range(0, 99);
        if (r < 35)
            return word_t'($urandom());
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return word_t'(1);
                default: return {{(SAMPLE_BITS-1){1'b1}}, 1'b0};
            endcase
        end
        if ($urandom_range(0, 49) == 0)
            drift_level = word_t'($urandom());
        delta = int'($urandom_range(0, 2047)) - 1024;
        drift_level = drift_level + word_t'(delta);
        return drift_level;
    endfunction

    task automatic add_row(input word_t v, input bit known, input word_t es, input word_t em,
                           input word_t el);
        sample_row_t row;
        row.smp   = v;
        row.known = known;
        row.avg   = '{s: es, m: em, l: el};
        dir_rows.push_back(row);
    endtask

    // present one word, hold it until accepted, then queue its expected averages
    task automatic send_word(input word_t v, input int gap, input bit known, input avg_set_t typed);
        avg_set_t p;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
        p = predict_averages(v);
        avg_exp_q.push_back(known ? typed : p);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (avg_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // stimulus
    initial
    begin
        // empty anchors: first samples pass straight through all levels
        add_row(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_row(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(32'hFFFF_FFFF, 1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        add_row(32'h0000_0001, 1'b0, '0, '0, '0);
        add_row(32'h0001_0000, 1'b0, '0, '0, '0);
        add_row(32'h8000_0000, 1'b0, '0, '0, '0);
        add_row(32'h7FFF_FFFF, 1'b0, '0, '0, '0);
        add_row(32'hFFFF_0000, 1'b0, '0, '0, '0);
        add_row(32'h0000_FFFF, 1'b0, '0, '0, '0);
        add_row(32'hAAAA_AAAA, 1'b0, '0, '0, '0);
        add_row(32'h5555_5555, 1'b0, '0, '0, '0);
        add_row(32'hFFFF_FFFE, 1'b0, '0, '0, '0);
        // second short window: mid slot one opens, then a full-scale run
        for (int i = 0; i < 12; i++)
            add_row(32'hFFFF_FFFF, 1'b0, '0, '0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].smp, pick_gap(), dir_rows[i].known, dir_rows[i].avg);
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // sender holds off once until the block has fully drained
            if (i == RANDOM_WORDS / 2)
                wait_drained();
            send_word(next_sample(), pick_gap(), 1'b0, '0);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver stall pattern: free stretches, short stalls, a few long ones
    initial
    begin
        int r;
        int len;
        wait (rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall <= 1'b0;
                len = (r < 8) ? $urandom_range(500, 3000) : $urandom_range(1, 40);
            end
            else if (r < 90)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 4);
            end
            else
            begin
                out_stall <= 1'b1;
                len = $urandom_range(20, 300);
            end
            repeat (len) @(posedge clk);
        end
    end

    // result check against the oldest expected word
    always @(posedge clk)
    begin : result_check
        avg_set_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (avg_exp_q.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual %h %h %h",
                         $time, avg_short, avg_mid, avg_long);
                errors++;
            end
            else
            begin
                want = avg_exp_q.pop_front();
                check_field("avg_short", want.s, avg_short);
                check_field("avg_mid", want.m, avg_mid);
                check_field("avg_long", want.l, avg_long);
            end
        end
    end

    // watchdog: too long without a handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mwba_pkg.sv
hdl/mwba_ram.sv
hdl/mwba_div.sv
hdl/multi_window_blended_average_unit.sv
dv/multi_window_blended_average_unit_tb.sv
